// ===== rtl/art_pkg.sv =====
// Shared types and constants for the ack/retry tracker.
// No dependencies; imported by art_ctrl, art_dp and ack_retry_tracker.
`default_nettype none

package art_pkg;

	localparam int DepthDefault = 16;
	localparam int MaxResults   = 16;
	localparam int ResCntW      = $clog2(MaxResults + 1);
	localparam int CfgDataW     = 16;
	localparam int CfgIdxW      = 1;

	localparam logic [1:0] CMD_TRACK = 2'd0;
	localparam logic [1:0] CMD_ACK   = 2'd1;
	localparam logic [1:0] CMD_CHECK = 2'd2;

	localparam logic [1:0] KIND_TRACKED = 2'd0;
	localparam logic [1:0] KIND_FULL    = 2'd1;
	localparam logic [1:0] KIND_RESEND  = 2'd2;
	localparam logic [1:0] KIND_GIVE_UP = 2'd3;

	localparam logic [CfgIdxW-1:0] REG_ACK_TIMEOUT = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_MAX_RETRIES = 1'd1;

	localparam logic [15:0] TimeoutReset = 16'd100;
	localparam logic [3:0]  RetriesReset = 4'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [3:0]  node;
		logic [7:0]  msg_type;
		logic        ack_ok;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] out_node;
		logic [7:0] out_type;
		logic [3:0] slot;
		logic       last;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;
		logic       s_inc;
		logic       trk_write;
		logic       push;
		logic [1:0] push_kind;
		logic       i_inc;
		logic       rd_next;
		logic       resend;
		logic       rm_start;
		logic       shift_write;
		logic       cnt_dec;
		logic       finish;
	} art_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       ack_ok;
		logic       full;
		logic       slot_free;
		logic       walk_end;
		logic       match;
		logic       timed_out;
		logic       ret_zero;
		logic       shift_end;
	} art_sts_t;

endpackage

`default_nettype wire

// ===== rtl/art_ctrl.sv =====
// Sequencer for the ack/retry tracker: dispatches commands, walks the list,
// drives the shift on removal. Depends on art_pkg.
`default_nettype none

module art_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire art_pkg::art_sts_t sts,
	output art_pkg::art_cmd_t cmd
);
	import art_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DISP  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_RD    = 3'd3;
	localparam logic [2:0] S_EV    = 3'd4;
	localparam logic [2:0] S_SH_RD = 3'd5;
	localparam logic [2:0] S_SH_WR = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.cmd)
					CMD_TRACK: begin
						if (sts.full) begin
							cmd.push      = 1'b1;
							cmd.push_kind = KIND_FULL;
							state_d       = S_FIN;
						end else begin
							state_d = S_SCAN;
						end
					end
					CMD_ACK, CMD_CHECK: state_d = S_RD;
					default:            state_d = S_FIN;
				endcase
			end
			S_SCAN: begin
				if (sts.slot_free) begin
					cmd.trk_write = 1'b1;
					cmd.push      = 1'b1;
					cmd.push_kind = KIND_TRACKED;
					state_d       = S_FIN;
				end else begin
					cmd.s_inc = 1'b1;
				end
			end
			S_RD: begin
				// entry i is read here, evaluated next cycle
				state_d = sts.walk_end ? S_FIN : S_EV;
			end
			S_EV: begin
				if (sts.cmd == CMD_ACK) begin
					if (sts.match) begin
						cmd.rm_start = sts.ack_ok;
						state_d      = sts.ack_ok ? S_SH_RD : S_FIN;
					end else begin
						cmd.i_inc = 1'b1;
						state_d   = S_RD;
					end
				end else if (!sts.timed_out) begin
					cmd.i_inc = 1'b1;
					state_d   = S_RD;
				end else if (sts.ret_zero) begin
					cmd.push      = 1'b1;
					cmd.push_kind = KIND_GIVE_UP;
					cmd.rm_start  = 1'b1;
					state_d       = S_SH_RD;
				end else begin
					cmd.push      = 1'b1;
					cmd.push_kind = KIND_RESEND;
					cmd.resend    = 1'b1;
					cmd.i_inc     = 1'b1;
					state_d       = S_RD;
				end
			end
			S_SH_RD: begin
				if (sts.shift_end) begin
					cmd.cnt_dec = 1'b1;
					// after a removal the check walk resumes at the same index
					state_d = (sts.cmd == CMD_ACK) ? S_FIN : S_RD;
				end else begin
					cmd.rd_next = 1'b1;
					state_d     = S_SH_WR;
				end
			end
			S_SH_WR: begin
				cmd.shift_write = 1'b1;
				state_d         = S_SH_RD;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

`ifndef ASSERT_OFF
	a_busy_ends_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(cmd.finish))
		else $error("busy dropped without finish");
	a_no_work_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !(cmd.push || cmd.trk_write || cmd.shift_write || cmd.resend))
		else $error("datapath command while idle");
`endif

endmodule

`default_nettype wire

// ===== rtl/art_dp.sv =====
// Datapath for the ack/retry tracker: entry memory, slot map, counters,
// config registers and the result register. Depends on art_pkg.
`default_nettype none

module art_dp #(
	parameter int DEPTH = art_pkg::DepthDefault
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire art_pkg::in_item_t         item,
	input  wire                            cfg_we,
	input  wire [art_pkg::CfgIdxW-1:0]     cfg_idx,
	input  wire [art_pkg::CfgDataW-1:0]    cfg_wdata,
	input  wire art_pkg::art_cmd_t         cmd,
	output art_pkg::art_sts_t              sts,
	output art_pkg::out_item_t             res,
	output logic                           res_valid
);
	import art_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef struct packed {
		logic [3:0]    node;
		logic [7:0]    mtype;
		logic [31:0]   sent;
		logic [3:0]    retries;
		logic [IW-1:0] slot;
	} entry_t;

	entry_t              mem_q [DEPTH];
	entry_t              rd_q;
	entry_t              wdata;
	logic                mem_we;
	logic [IW-1:0]       waddr, raddr;

	in_item_t            in_q;
	logic [15:0]         tmo_q;
	logic [3:0]          mret_q;
	logic [CW-1:0]       cnt_q, i_q, j_q, jn;
	logic [IW-1:0]       s_q;
	logic [DEPTH-1:0]    sbusy_q;
	logic [ResCntW-1:0]  n_q;
	out_item_t           pend_q, push_d;
	logic                pend_v_q;
	logic [31:0]         age;
	logic [IW+3:0]       slot_ext;

	assign jn  = j_q + 1'b1;
	assign age = in_q.now_ms - rd_q.sent;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmo_q  <= TimeoutReset;
			mret_q <= RetriesReset;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ACK_TIMEOUT: tmo_q  <= cfg_wdata;
				REG_MAX_RETRIES: mret_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= item;
		end
	end

	// entry memory: one write, one registered read
	always_comb begin
		mem_we = 1'b0;
		waddr  = i_q[IW-1:0];
		wdata  = rd_q;
		if (cmd.trk_write) begin
			mem_we        = 1'b1;
			waddr         = cnt_q[IW-1:0];
			wdata.node    = in_q.node;
			wdata.mtype   = in_q.msg_type;
			wdata.sent    = in_q.now_ms;
			wdata.retries = mret_q;
			wdata.slot    = s_q;
		end else if (cmd.resend) begin
			mem_we        = 1'b1;
			wdata.retries = rd_q.retries - 4'd1;
			wdata.sent    = in_q.now_ms;
		end else if (cmd.shift_write) begin
			mem_we = 1'b1;
			waddr  = j_q[IW-1:0];
		end
	end

	assign raddr = cmd.rd_next ? jn[IW-1:0] : i_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	// counters and slot map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sbusy_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			s_q     <= '0;
			n_q     <= '0;
		end else begin
			if (cmd.load) begin
				i_q <= '0;
				s_q <= '0;
				n_q <= '0;
			end
			if (cmd.s_inc) begin
				s_q <= s_q + 1'b1;
			end
			if (cmd.trk_write) begin
				sbusy_q[s_q] <= 1'b1;
				cnt_q        <= cnt_q + 1'b1;
			end
			if (cmd.i_inc) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.push) begin
				n_q <= n_q + 1'b1;
			end
			if (cmd.rm_start) begin
				sbusy_q[rd_q.slot] <= 1'b0;
				j_q                <= i_q;
			end
			if (cmd.shift_write) begin
				j_q <= jn;
			end
			if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// result fields for a new transfer
	assign slot_ext = {4'd0, rd_q.slot};
	always_comb begin
		push_d.kind = cmd.push_kind;
		push_d.last = 1'b0;
		case (cmd.push_kind)
			KIND_TRACKED: begin
				push_d.out_node = in_q.node;
				push_d.out_type = in_q.msg_type;
				push_d.slot     = 4'(s_q);
			end
			KIND_FULL: begin
				push_d.out_node = in_q.node;
				push_d.out_type = in_q.msg_type;
				push_d.slot     = 4'd0;
			end
			default: begin
				push_d.out_node = rd_q.node;
				push_d.out_type = rd_q.mtype;
				push_d.slot     = slot_ext[3:0];
			end
		endcase
	end

	// one result held back so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q  <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			if (cmd.push) begin
				pend_v_q  <= 1'b1;
				res_valid <= pend_v_q;
			end else if (cmd.finish) begin
				pend_v_q  <= 1'b0;
				res_valid <= pend_v_q;
			end
		end
	end

	// pend_q.last is always clear; only the final transfer sets it
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			pend_q <= push_d;
			res    <= pend_q;
		end else if (cmd.finish) begin
			res <= out_item_t'({pend_q[$bits(out_item_t)-1:1], 1'b1});
		end
	end

	always_comb begin
		sts.cmd       = in_q.cmd;
		sts.ack_ok    = in_q.ack_ok;
		sts.full      = (cnt_q == CW'(DEPTH));
		sts.slot_free = !sbusy_q[s_q];
		sts.walk_end  = (i_q >= cnt_q) || (n_q == ResCntW'(MaxResults));
		sts.match     = (rd_q.node == in_q.node) && (rd_q.mtype == in_q.msg_type);
		sts.timed_out = (age >= {16'd0, tmo_q});
		sts.ret_zero  = (rd_q.retries == 4'd0);
		sts.shift_end = (jn >= cnt_q);
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above depth");
	a_track_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.trk_write |-> (!sbusy_q[s_q] && cnt_q < CW'(DEPTH)))
		else $error("track into busy slot or full list");
	a_remove_busy_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rm_start |-> sbusy_q[rd_q.slot])
		else $error("removed entry held a free slot");
	a_push_finish_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.finish))
		else $error("push and finish together");
`endif

endmodule

`default_nettype wire

// ===== rtl/ack_retry_tracker.sv =====
// Top level of the ack/retry tracker: controller plus datapath.
// Depends on art_pkg, art_ctrl and art_dp.
`default_nettype none

// Tracks sent messages awaiting acknowledge. A command is taken when start is
// high and busy is low; results appear one per res_valid pulse and must be
// taken in that cycle, the final one of a command with res.last set. Entries
// live in a single-port-read memory walked one at a time, so time per command
// is set by that walk: track scans past each busy slot below the lowest free
// one (a full list is refused without a scan); ack and check visit the entries
// one by one, and each removal moves every later entry up by one place.
// Results of a command are delayed one transfer so that last can be marked.
// No clearing pass is needed after reset.
module ack_retry_tracker #(
	parameter int DEPTH = art_pkg::DepthDefault
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire art_pkg::in_item_t       item,
	input  wire                          cfg_we,
	input  wire [art_pkg::CfgIdxW-1:0]   cfg_idx,
	input  wire [art_pkg::CfgDataW-1:0]  cfg_wdata,
	output art_pkg::out_item_t           res,
	output logic                         res_valid
);
	import art_pkg::*;

	art_cmd_t cmd;
	art_sts_t sts;

	art_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	art_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.res       (res),
		.res_valid (res_valid)
	);

endmodule

`default_nettype wire
